// ===== hdl/pp_pkg.sv =====
// Package for the parallel printer port: opcodes, bit masks and shared types.
package pp_pkg;

    // Bus access / event codes carried in tuser
    typedef enum logic [2:0] {
        OP_WR_DATA = 3'd0,
        OP_WR_CTRL = 3'd1,
        OP_RD_DATA = 3'd2,
        OP_RD_STAT = 3'd3,
        OP_RD_CTRL = 3'd4,
        OP_TICK    = 3'd5,
        OP_BUTTON  = 3'd6,
        OP_RESET   = 3'd7
    } op_t;

    // Configuration register indexes
    localparam logic CFG_PRINTER_ENABLED = 1'b0;
    localparam logic CFG_IDLE_TIMEOUT    = 1'b1;

    // Control and status bit patterns
    localparam logic [7:0] BIT_STROBE = 8'h01;
    localparam logic [7:0] BIT_AUTOLF = 8'h02;
    localparam logic [7:0] BIT_INIT   = 8'h04;
    localparam logic [7:0] CTRL_HIGH  = 8'he0;
    localparam logic [7:0] CTRL_MASK  = 8'hfd;
    localparam logic [7:0] STAT_LOW   = 8'h1f;
    localparam logic [7:0] STAT_ACK   = 8'h40;
    localparam logic [7:0] STAT_BUSY  = 8'h80;
    localparam logic [7:0] STAT_NONE  = 8'hdf;

    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd500;

    // Configuration registers as seen by the core
    typedef struct packed {
        logic        printer_enabled;
        logic [15:0] idle_timeout;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic       hard_reset;
        logic       form_feed;
        logic [7:0] print_byte;
        logic       print_valid;
        logic [7:0] read_value;
    } result_t;

endpackage

// ===== hdl/pp_core.sv =====
// Port state (latches, flags, idle timer) and the per-transfer update logic.
module pp_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  pp_pkg::op_t    op,
    input  logic [7:0]     wdata,
    input  pp_pkg::cfg_t   cfg,
    output pp_pkg::result_t result
);

    logic [7:0]  data_latch_reg,      data_latch_next;
    logic [7:0]  control_latch_reg,   control_latch_next;
    logic        printer_present_reg, printer_present_next;
    logic        ack_pending_reg,     ack_pending_next;
    logic        autofeed_bit_reg,    autofeed_bit_next;
    logic        timer_armed_reg,     timer_armed_next;
    logic [15:0] timer_count_reg,     timer_count_next;

    logic init_rise;
    logic strobe_fall;
    logic present_now;

    assign init_rise   = ((wdata & pp_pkg::BIT_INIT) != 8'h00)
                       && ((control_latch_reg & pp_pkg::BIT_INIT) == 8'h00);
    assign strobe_fall = ((wdata & pp_pkg::BIT_STROBE) == 8'h00)
                       && ((control_latch_reg & pp_pkg::BIT_STROBE) != 8'h00);
    // presence after a strobe may bring the printer online
    assign present_now = printer_present_reg || (strobe_fall && cfg.printer_enabled);

    // Next state and result for the item at the input register
    always_comb
    begin
        data_latch_next      = data_latch_reg;
        control_latch_next   = control_latch_reg;
        printer_present_next = printer_present_reg;
        ack_pending_next     = ack_pending_reg;
        autofeed_bit_next    = autofeed_bit_reg;
        timer_armed_next     = timer_armed_reg;
        timer_count_next     = timer_count_reg;
        result               = '0;

        case (op)
            pp_pkg::OP_WR_DATA:
            begin
                data_latch_next = wdata;
            end
            pp_pkg::OP_WR_CTRL:
            begin
                if (init_rise && printer_present_reg)
                begin
                    result.hard_reset = 1'b1;
                    ack_pending_next  = 1'b0;
                    timer_armed_next  = 1'b0;
                end
                if (strobe_fall)
                begin
                    printer_present_next = present_now;
                    if (present_now)
                    begin
                        result.print_valid = 1'b1;
                        result.print_byte  = data_latch_reg;
                        ack_pending_next   = 1'b1;
                    end
                    if (cfg.idle_timeout != 16'd0)
                    begin
                        timer_armed_next = 1'b1;
                        timer_count_next = cfg.idle_timeout;
                    end
                end
                control_latch_next = wdata;
                if (present_now)
                begin
                    autofeed_bit_next = wdata[1];
                end
            end
            pp_pkg::OP_RD_DATA:
            begin
                result.read_value = data_latch_reg;
            end
            pp_pkg::OP_RD_STAT:
            begin
                if (!printer_present_reg)
                begin
                    result.read_value = pp_pkg::STAT_NONE;
                end
                else if (ack_pending_reg)
                begin
                    result.read_value = pp_pkg::STAT_LOW | pp_pkg::STAT_BUSY;
                    ack_pending_next  = 1'b0;
                end
                else
                begin
                    result.read_value = pp_pkg::STAT_LOW | pp_pkg::STAT_BUSY
                                      | pp_pkg::STAT_ACK;
                end
            end
            pp_pkg::OP_RD_CTRL:
            begin
                if (!printer_present_reg)
                begin
                    result.read_value = pp_pkg::CTRL_HIGH | control_latch_reg;
                end
                else
                begin
                    result.read_value = pp_pkg::CTRL_HIGH
                                      | (autofeed_bit_reg ? pp_pkg::BIT_AUTOLF : 8'h00)
                                      | (control_latch_reg & pp_pkg::CTRL_MASK);
                end
            end
            pp_pkg::OP_TICK:
            begin
                if (timer_armed_reg)
                begin
                    if (timer_count_reg <= 16'd1)
                    begin
                        timer_count_next = 16'd0;
                        timer_armed_next = 1'b0;
                        result.form_feed = printer_present_reg;
                    end
                    else
                    begin
                        timer_count_next = timer_count_reg - 16'd1;
                    end
                end
            end
            pp_pkg::OP_BUTTON:
            begin
                if (printer_present_reg)
                begin
                    result.form_feed = 1'b1;
                    timer_armed_next = 1'b0;
                end
            end
            default:
            begin
                // port reset: state back to its reset values
                data_latch_next      = 8'h00;
                control_latch_next   = pp_pkg::BIT_INIT;
                printer_present_next = 1'b0;
                ack_pending_next     = 1'b0;
                autofeed_bit_next    = 1'b0;
                timer_armed_next     = 1'b0;
                timer_count_next     = 16'd0;
            end
        endcase
    end

    // State registers, updated once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_latch_reg      <= 8'h00;
            control_latch_reg   <= pp_pkg::BIT_INIT;
            printer_present_reg <= 1'b0;
            ack_pending_reg     <= 1'b0;
            autofeed_bit_reg    <= 1'b0;
            timer_armed_reg     <= 1'b0;
            timer_count_reg     <= 16'd0;
        end
        else if (fire)
        begin
            data_latch_reg      <= data_latch_next;
            control_latch_reg   <= control_latch_next;
            printer_present_reg <= printer_present_next;
            ack_pending_reg     <= ack_pending_next;
            autofeed_bit_reg    <= autofeed_bit_next;
            timer_armed_reg     <= timer_armed_next;
            timer_count_reg     <= timer_count_next;
        end
    end

endmodule

// ===== hdl/parallel_printer_port.sv =====
// Parallel printer port: input register, port state core, output register.
// An item passes the input register, then the output register, and its result
// waits there while m_tready is low. Throughput: one item per cycle unless
// the output stalls; the input and output registers form a two-stage
// pipeline, and the state core updates in the cycle an item moves on.
// Reset (rst_n, async, active low): state cleared, control latch 0x04, both stages empty.
module parallel_printer_port
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] wdata
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] read_value, [8] print_valid,
                                   // [16:9] print_byte, [17] form_feed,
                                   // [18] hard_reset, [23:19] zero
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    pp_pkg::cfg_t    cfg_reg;
    logic            in_valid_reg;
    pp_pkg::op_t     in_op_reg;
    logic [7:0]      in_wdata_reg;
    logic            out_valid_reg;
    pp_pkg::result_t out_data_reg;
    pp_pkg::result_t result;
    logic            advance;

    // an item moves on when the output register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.printer_enabled <= 1'b0;
            cfg_reg.idle_timeout    <= pp_pkg::IDLE_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == pp_pkg::CFG_PRINTER_ENABLED)
            begin
                cfg_reg.printer_enabled <= cfg_wdata[0];
            end
            else
            begin
                cfg_reg.idle_timeout <= cfg_wdata;
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= pp_pkg::op_t'(s_tuser);
            in_wdata_reg <= s_tdata;
        end
    end

    // Port state and per-item logic
    pp_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .op     (in_op_reg),
        .wdata  (in_wdata_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_data_reg.hard_reset, out_data_reg.form_feed,
                       out_data_reg.print_byte, out_data_reg.print_valid,
                       out_data_reg.read_value};

    // Assertions
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("pending input item dropped while output stalled");

    a_print_src: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.print_valid |-> in_op_reg == pp_pkg::OP_WR_CTRL)
        else $error("print byte from an opcode other than write control");

    a_ff_src: assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.form_feed
        |-> (in_op_reg == pp_pkg::OP_TICK) || (in_op_reg == pp_pkg::OP_BUTTON))
        else $error("form feed from an opcode other than tick or button");

    a_rv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg != pp_pkg::OP_RD_DATA) && (in_op_reg != pp_pkg::OP_RD_STAT)
        && (in_op_reg != pp_pkg::OP_RD_CTRL) |-> result.read_value == 8'h00)
        else $error("nonzero read value on a non-read opcode");

endmodule

// ===== dv/parallel_printer_port_tb.sv =====
// Testbench for parallel_printer_port: stream driver, port-state scoreboard, watchdog.
module parallel_printer_port_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 153;

    // Scoreboard: tracks the port state and holds the expected results in order
    class port_scoreboard;
        bit              enabled;
        logic [15:0]     timeout;
        logic [7:0]      data_latch;
        logic [7:0]      ctrl_latch;
        bit              present;
        bit              ack_pending;
        bit              autofeed;
        bit              armed;
        logic [15:0]     count;
        pp_pkg::result_t pending_results[$];
        int              mismatches;

        function new();
            enabled    = 1'b0;
            timeout    = pp_pkg::IDLE_TIMEOUT_RESET;
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            data_latch  = 8'h00;
            ctrl_latch  = pp_pkg::BIT_INIT;
            present     = 1'b0;
            ack_pending = 1'b0;
            autofeed    = 1'b0;
            armed       = 1'b0;
            count       = 16'd0;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == pp_pkg::CFG_PRINTER_ENABLED)
                enabled = value[0];
            else
                timeout = value;
        endfunction

        // Update the port state for one accepted access and queue its result
        function void note_access(pp_pkg::op_t op, logic [7:0] wd);
            pp_pkg::result_t r;
            r = '0;
            case (op)
                pp_pkg::OP_WR_DATA:
                    data_latch = wd;
                pp_pkg::OP_WR_CTRL:
                begin
                    // rising init edge with a printer attached
                    if ((wd & pp_pkg::BIT_INIT) != 0 && (ctrl_latch & pp_pkg::BIT_INIT) == 0
                        && present)
                    begin
                        r.hard_reset = 1'b1;
                        ack_pending  = 1'b0;
                        armed        = 1'b0;
                    end
                    // falling strobe edge
                    if ((wd & pp_pkg::BIT_STROBE) == 0
                        && (ctrl_latch & pp_pkg::BIT_STROBE) != 0)
                    begin
                        if (!present && enabled)
                            present = 1'b1;
                        if (present)
                        begin
                            r.print_valid = 1'b1;
                            r.print_byte  = data_latch;
                            ack_pending   = 1'b1;
                        end
                        if (timeout != 16'd0)
                        begin
                            armed = 1'b1;
                            count = timeout;
                        end
                    end
                    ctrl_latch = wd;
                    if (present)
                        autofeed = (wd & pp_pkg::BIT_AUTOLF) != 0;
                end
                pp_pkg::OP_RD_DATA:
                    r.read_value = data_latch;
                pp_pkg::OP_RD_STAT:
                begin
                    if (!present)
                        r.read_value = pp_pkg::STAT_NONE;
                    else
                    begin
                        r.read_value = pp_pkg::STAT_LOW | pp_pkg::STAT_BUSY;
                        if (ack_pending)
                            ack_pending = 1'b0;
                        else
                            r.read_value = r.read_value | pp_pkg::STAT_ACK;
                    end
                end
                pp_pkg::OP_RD_CTRL:
                begin
                    if (!present)
                        r.read_value = pp_pkg::CTRL_HIGH | ctrl_latch;
                    else
                        r.read_value = pp_pkg::CTRL_HIGH
                                       | (autofeed ? pp_pkg::BIT_AUTOLF : 8'h00)
                                       | (ctrl_latch & pp_pkg::CTRL_MASK);
                end
                pp_pkg::OP_TICK:
                begin
                    if (armed)
                    begin
                        if (count <= 16'd1)
                        begin
                            count = 16'd0;
                            armed = 1'b0;
                            if (present)
                                r.form_feed = 1'b1;
                        end
                        else
                            count = count - 16'd1;
                    end
                end
                pp_pkg::OP_BUTTON:
                begin
                    if (present)
                    begin
                        r.form_feed = 1'b1;
                        armed       = 1'b0;
                    end
                end
                default:
                    clear_state();
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, int expected, int actual);
            if (expected != actual)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
                mismatches++;
            end
        endfunction

        // Compare one output transfer with the oldest expected result
        function void check_result(logic [23:0] data);
            pp_pkg::result_t exp_r;
            pp_pkg::result_t got;
            if (pending_results.size() == 0)
            begin
                $error("result transfer 0x%06h with no expected result waiting", data);
                mismatches++;
                return;
            end
            exp_r = pending_results.pop_front();
            got   = pp_pkg::result_t'(data[18:0]);
            check_field("read_value", exp_r.read_value, got.read_value);
            check_field("print_valid", exp_r.print_valid, got.print_valid);
            check_field("print_byte", exp_r.print_byte, got.print_byte);
            check_field("form_feed", exp_r.form_feed, got.form_feed);
            check_field("hard_reset", exp_r.hard_reset, got.hard_reset);
            check_field("pad", 0, data[23:19]);
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic [2:0]  s_tuser   = 3'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    port_scoreboard sb = new();

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int items_sent = 0;

    bit          phase_enable [PHASE_COUNT] = '{1, 1, 0, 1, 1, 0, 1, 1};
    logic [15:0] phase_timeout [PHASE_COUNT] =
        '{16'd3, 16'd1, 16'd0, 16'd65535, 16'd5, 16'd2, 16'd7, 16'd0};

    parallel_printer_port dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Monitor: note input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_access(pp_pkg::op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    initial
    begin
        int holds_served;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served < hold_req)
            begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Offer one access and wait for its transfer
    task automatic send(pp_pkg::op_t op, logic [7:0] wd);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= wd;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Wait until every expected result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_cfg(logic idx, logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly strobe sequences and tick bursts, some noise
    task automatic run_random(int n);
        int target;
        int kind;
        int k;
        target = items_sent + n;
        while (items_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                send(pp_pkg::OP_WR_DATA, rand_byte());
                send(pp_pkg::OP_WR_CTRL, rand_byte() | pp_pkg::BIT_STROBE);
                send(pp_pkg::OP_WR_CTRL, rand_byte() & ~pp_pkg::BIT_STROBE);
                if ($urandom_range(1) == 1)
                    send(pp_pkg::OP_RD_STAT, rand_byte());
                if ($urandom_range(3) == 0)
                    send(pp_pkg::OP_RD_CTRL, rand_byte());
            end
            else if (kind < 75)
            begin
                k = $urandom_range(6, 1);
                repeat (k) send(pp_pkg::OP_TICK, rand_byte());
                if ($urandom_range(3) == 0)
                    send(pp_pkg::OP_BUTTON, rand_byte());
            end
            else if (kind < 85)
            begin
                case ($urandom_range(2))
                    0: send(pp_pkg::OP_RD_STAT, rand_byte());
                    1: send(pp_pkg::OP_RD_CTRL, rand_byte());
                    default: send(pp_pkg::OP_RD_DATA, rand_byte());
                endcase
            end
            else if (kind < 92)
            begin
                // init low then high
                send(pp_pkg::OP_WR_CTRL, rand_byte() & ~pp_pkg::BIT_INIT);
                send(pp_pkg::OP_WR_CTRL, rand_byte() | pp_pkg::BIT_INIT);
            end
            else
                send(pp_pkg::op_t'($urandom_range(7)), rand_byte());
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: power-on settings, no printer can come online
        send(pp_pkg::OP_RD_STAT, 8'h00);
        send(pp_pkg::OP_RD_CTRL, 8'hff);
        send(pp_pkg::OP_RD_DATA, 8'h5a);
        send(pp_pkg::OP_WR_DATA, 8'hff);
        send(pp_pkg::OP_WR_CTRL, 8'h05);
        send(pp_pkg::OP_WR_CTRL, 8'h00);
        send(pp_pkg::OP_BUTTON, 8'hff);
        send(pp_pkg::OP_TICK, 8'h00);

        // Directed: printer online, short timeout
        write_cfg(pp_pkg::CFG_PRINTER_ENABLED, 16'h0001);
        write_cfg(pp_pkg::CFG_IDLE_TIMEOUT, 16'd2);
        send(pp_pkg::OP_WR_DATA, 8'ha5);
        send(pp_pkg::OP_WR_CTRL, 8'h01);
        send(pp_pkg::OP_WR_CTRL, 8'h02);
        send(pp_pkg::OP_RD_STAT, 8'h00);
        send(pp_pkg::OP_RD_STAT, 8'h00);
        send(pp_pkg::OP_RD_CTRL, 8'h00);
        send(pp_pkg::OP_TICK, 8'h00);
        send(pp_pkg::OP_TICK, 8'h00);
        send(pp_pkg::OP_TICK, 8'h00);
        send(pp_pkg::OP_WR_CTRL, 8'h05);
        send(pp_pkg::OP_WR_CTRL, 8'hfc);
        send(pp_pkg::OP_RD_CTRL, 8'h00);
        send(pp_pkg::OP_BUTTON, 8'h00);
        send(pp_pkg::OP_WR_DATA, 8'h00);
        send(pp_pkg::OP_RD_DATA, 8'h00);
        send(pp_pkg::OP_RESET, 8'hff);
        send(pp_pkg::OP_RD_STAT, 8'h00);
        send(pp_pkg::OP_RD_CTRL, 8'h00);

        // Random phases over several settings and idle patterns
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_cfg(pp_pkg::CFG_PRINTER_ENABLED, {15'd0, phase_enable[p]});
            write_cfg(pp_pkg::CFG_IDLE_TIMEOUT, phase_timeout[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p % 4 == 0)
                hold_req++;
            run_random(PHASE_ITEMS);
        end

        // Final drain
        drain();
        repeat (8) @(posedge clk);
        if (sb.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
